// ===== hdl/pyb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pyb_pkg
// Shared types and constants of the packed YUV to planar block writer.
// ----------------------------------------------------------------------------
package pyb_pkg;

    // Default frame size limits in macroblocks.
    localparam int DEF_MAX_BLOCKS_WIDE = 64;
    localparam int DEF_MAX_BLOCKS_HIGH = 48;

    // Fixed field widths.
    localparam int ADDR_W     = 21;
    localparam int PAIR_W     = 64;
    localparam int BYTE2_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;
    localparam int BCOL_W     = 7;
    localparam int BROW_W     = 6;
    localparam int CMP_W      = 16;

    // Register reset values.
    localparam logic              RST_CHROMA_MODE = 1'b1;
    localparam logic [BCOL_W-1:0] RST_BLOCKS_WIDE = 7'd22;
    localparam logic [BROW_W-1:0] RST_BLOCKS_HIGH = 6'd18;
    localparam logic [BCOL_W-1:0] RST_FIRST_COL   = 7'd0;
    localparam logic [BCOL_W-1:0] RST_END_COL     = 7'd22;
    localparam logic [BROW_W-1:0] RST_FIRST_ROW   = 6'd0;
    localparam logic [BROW_W-1:0] RST_END_ROW     = 6'd18;

    // Chroma layout codes.
    localparam logic MODE_422 = 1'b0;
    localparam logic MODE_420 = 1'b1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHROMA_MODE = 3'd0,
        REG_BLOCKS_WIDE = 3'd1,
        REG_BLOCKS_HIGH = 3'd2,
        REG_FIRST_COL   = 3'd3,
        REG_END_COL     = 3'd4,
        REG_FIRST_ROW   = 3'd5,
        REG_END_ROW     = 3'd6
    } cfg_reg_t;

    // Region window and chroma layout as seen by the position tracker.
    typedef struct packed {
        logic              chroma_mode;
        logic [BCOL_W-1:0] first_col;
        logic [BCOL_W-1:0] end_col;
        logic [BROW_W-1:0] first_row;
        logic [BROW_W-1:0] end_row;
    } region_t;

    // Per-pair status from the position tracker.
    typedef struct packed {
        logic in_window;   // macroblock lies in the written area
        logic chroma_row;  // this row carries chroma
    } pos_status_t;

endpackage : pyb_pkg
`default_nettype wire

// ===== hdl/pyb_position.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pyb_position
// Column and row tracker of the incoming pixel pairs. It folds a position
// that lies past the frame back into it, reports the current position and
// whether its macroblock is written, and steps to the next pair.
// ----------------------------------------------------------------------------
module pyb_position
    import pyb_pkg::*;
#(
    parameter int COL_W = 9,
    parameter int ROW_W = 10,
    parameter int WP_W  = 10,
    parameter int RW_W  = 10
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             advance,
    input  wire logic [WP_W-1:0]  wpairs,
    input  wire logic [RW_W-1:0]  rows,
    input  wire region_t          region,
    output logic      [COL_W-1:0] cur_col,
    output logic      [ROW_W-1:0] cur_row,
    output pos_status_t           status
);

    localparam int CW = (COL_W + 1 > WP_W) ? COL_W + 1 : WP_W;
    localparam int RW = (ROW_W + 1 > RW_W) ? ROW_W + 1 : RW_W;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic [RW-1:0]    row_pre;
    logic [COL_W-1:0] col_n;
    logic [ROW_W-1:0] row_n;
    logic [CW-1:0]    col_inc;
    logic [RW-1:0]    row_inc;
    logic [CMP_W-1:0] bx, by;

    // Fold a stale position back into the frame before use.
    always_comb begin
        if (CW'(col_reg) >= CW'(wpairs)) begin
            col_n   = '0;
            row_pre = RW'(row_reg) + RW'(1);
        end else begin
            col_n   = col_reg;
            row_pre = RW'(row_reg);
        end
        row_n = (row_pre >= RW'(rows)) ? '0 : ROW_W'(row_pre);
    end

    // Step to the following pair, wrapping at row and frame ends.
    always_comb begin
        col_inc = CW'(col_n) + CW'(1);
        row_inc = RW'(row_n) + RW'(1);
        if (col_inc >= CW'(wpairs)) begin
            col_next = '0;
            row_next = (row_inc >= RW'(rows)) ? '0 : ROW_W'(row_inc);
        end else begin
            col_next = COL_W'(col_inc);
            row_next = row_n;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (advance) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Macroblock coordinates: eight pairs across, sixteen rows down.
    assign bx = CMP_W'(col_n >> 3);
    assign by = CMP_W'(row_n >> 4);

    always_comb begin
        status.in_window  = 1'b1;
        status.chroma_row = 1'b1;
        if (region.chroma_mode == MODE_420) begin
            status.chroma_row = ~row_n[0];
            if (bx < CMP_W'(region.first_col) || bx >= CMP_W'(region.end_col) ||
                by < CMP_W'(region.first_row) || by >= CMP_W'(region.end_row)) begin
                status.in_window = 1'b0;
            end
        end
    end

    assign cur_col = col_n;
    assign cur_row = row_n;

endmodule : pyb_position
`default_nettype wire

// ===== hdl/packed_yuv_to_planar_block_writer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A result word passes the input, product and output registers before it is on m_*.
// Throughput: one pair word per cycle while m_ready holds no word back; the three register stages (input,
// product, output) each hand over under their own valid and ready.
// Pairs whose macroblock is not written leave no word.
// Reset (aresetn low, synchronous) empties the stages, sets the position to
// column 0, row 0 and loads the register defaults.
// ----------------------------------------------------------------------------
// packed_yuv_to_planar_block_writer
// Converts packed 4:2:2 pixel pairs into planar luma and chroma writes for
// the macroblocks flagged for sending (in 4:2:0 mode, only inside the window).
// ----------------------------------------------------------------------------
module packed_yuv_to_planar_block_writer
    import pyb_pkg::*;
#(
    parameter int MAX_BLOCKS_WIDE = DEF_MAX_BLOCKS_WIDE,
    parameter int MAX_BLOCKS_HIGH = DEF_MAX_BLOCKS_HIGH
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Configuration writes
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // Pixel pair input
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [PAIR_W-1:0]     s_pair_bytes,
    input  wire logic                  s_block_send,
    // Planar write output
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic      [ADDR_W-1:0]     m_luma_addr,
    output logic      [BYTE2_W-1:0]    m_luma_pair,
    output logic                       m_chroma_write,
    output logic      [ADDR_W-1:0]     m_u_addr,
    output logic      [ADDR_W-1:0]     m_v_addr,
    output logic      [BYTE2_W-1:0]    m_uv_pair
);

    localparam int BW_W   = $clog2(MAX_BLOCKS_WIDE + 1);
    localparam int BH_W   = $clog2(MAX_BLOCKS_HIGH + 1);
    localparam int WP_W   = BW_W + 3;
    localparam int RW_W   = BH_W + 4;
    localparam int COL_W  = $clog2(MAX_BLOCKS_WIDE * 8);
    localparam int ROW_W  = $clog2(MAX_BLOCKS_HIGH * 16);
    localparam int PROD_W = ROW_W + WP_W;
    localparam int BB_W   = BW_W + BH_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic              chroma_mode_reg;
    logic [BCOL_W-1:0] blocks_wide_reg;
    logic [BROW_W-1:0] blocks_high_reg;
    logic [BCOL_W-1:0] first_col_reg, end_col_reg;
    logic [BROW_W-1:0] first_row_reg, end_row_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chroma_mode_reg <= RST_CHROMA_MODE;
            blocks_wide_reg <= RST_BLOCKS_WIDE;
            blocks_high_reg <= RST_BLOCKS_HIGH;
            first_col_reg   <= RST_FIRST_COL;
            end_col_reg     <= RST_END_COL;
            first_row_reg   <= RST_FIRST_ROW;
            end_row_reg     <= RST_END_ROW;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_CHROMA_MODE: chroma_mode_reg <= cfg_data[0];
                REG_BLOCKS_WIDE: blocks_wide_reg <= cfg_data[BCOL_W-1:0];
                REG_BLOCKS_HIGH: blocks_high_reg <= cfg_data[BROW_W-1:0];
                REG_FIRST_COL:   first_col_reg   <= cfg_data[BCOL_W-1:0];
                REG_END_COL:     end_col_reg     <= cfg_data[BCOL_W-1:0];
                REG_FIRST_ROW:   first_row_reg   <= cfg_data[BROW_W-1:0];
                REG_END_ROW:     end_row_reg     <= cfg_data[BROW_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Frame geometry: clamp the size, derive pairs per row and rows.
    // ------------------------------------------------------------------
    logic [BW_W-1:0] bw;
    logic [BH_W-1:0] bh;
    logic [WP_W-1:0] wpairs;
    logic [RW_W-1:0] rows;
    logic [BB_W-1:0] blocks_area;

    always_comb begin
        if (blocks_wide_reg == '0) begin
            bw = BW_W'(1);
        end else if (32'(blocks_wide_reg) > 32'(MAX_BLOCKS_WIDE)) begin
            bw = BW_W'(MAX_BLOCKS_WIDE);
        end else begin
            bw = BW_W'(blocks_wide_reg);
        end
        if (blocks_high_reg == '0) begin
            bh = BH_W'(1);
        end else if (32'(blocks_high_reg) > 32'(MAX_BLOCKS_HIGH)) begin
            bh = BH_W'(MAX_BLOCKS_HIGH);
        end else begin
            bh = BH_W'(blocks_high_reg);
        end
    end

    assign wpairs      = {bw, 3'b000};
    assign rows        = {bh, 4'b0000};
    assign blocks_area = BB_W'(bw) * BB_W'(bh);

    // Frame size (blocks times 256) and the V plane base, registered.
    logic [ADDR_W-1:0] fsize_reg, vbase_reg;
    logic [ADDR_W-1:0] fsize_full, v_off;

    assign fsize_full = ADDR_W'({blocks_area, 8'd0});
    assign v_off      = (chroma_mode_reg == MODE_420) ? ADDR_W'({blocks_area, 6'd0})
                                                      : ADDR_W'({blocks_area, 7'd0});

    always_ff @(posedge aclk) begin
        fsize_reg <= fsize_full;
        vbase_reg <= fsize_full + v_off;
    end

    // ------------------------------------------------------------------
    // Position tracking
    // ------------------------------------------------------------------
    logic [COL_W-1:0] cur_col;
    logic [ROW_W-1:0] cur_row;
    pos_status_t      status;
    region_t          region;
    logic             s_fire;

    assign region = '{chroma_mode: chroma_mode_reg, first_col: first_col_reg,
                      end_col: end_col_reg, first_row: first_row_reg,
                      end_row: end_row_reg};

    assign s_fire = s_valid && s_ready;

    pyb_position #(
        .COL_W (COL_W),
        .ROW_W (ROW_W),
        .WP_W  (WP_W),
        .RW_W  (RW_W)
    ) u_position (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (s_fire),
        .wpairs  (wpairs),
        .rows    (rows),
        .region  (region),
        .cur_col (cur_col),
        .cur_row (cur_row),
        .status  (status)
    );

    // ------------------------------------------------------------------
    // Stage handshakes
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, m_valid_reg;
    logic rdy1, rdy2, rdy3;

    assign rdy3    = !m_valid_reg || m_ready;
    assign rdy2    = !s2_valid_reg || rdy3;
    assign rdy1    = !s1_valid_reg || rdy2;
    assign s_ready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (rdy1) begin
                s1_valid_reg <= s_fire && s_block_send && status.in_window;
            end
            if (rdy2) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (rdy3) begin
                m_valid_reg <= s2_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: capture the pair, its position and its bytes.
    // ------------------------------------------------------------------
    logic [COL_W-1:0]   s1_col_reg;
    logic [ROW_W-1:0]   s1_row_reg;
    logic               s1_cw_reg;
    logic [BYTE2_W-1:0] s1_luma_reg, s1_uv_reg;

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            s1_col_reg  <= cur_col;
            s1_row_reg  <= cur_row;
            s1_cw_reg   <= status.chroma_row;
            s1_luma_reg <= {s_pair_bytes[55:48], s_pair_bytes[23:16]};
            s1_uv_reg   <= {s_pair_bytes[63:56], s_pair_bytes[47:40]};
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: row times half width. Luma is twice this, 4:2:2 chroma
    // uses it as is and 4:2:0 chroma (even rows) uses half of it.
    // ------------------------------------------------------------------
    logic [PROD_W-1:0]  s2_prod_reg;
    logic [COL_W-1:0]   s2_col_reg;
    logic               s2_cw_reg;
    logic [BYTE2_W-1:0] s2_luma_reg, s2_uv_reg;

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            s2_prod_reg <= PROD_W'(s1_row_reg) * PROD_W'(wpairs);
            s2_col_reg  <= s1_col_reg;
            s2_cw_reg   <= s1_cw_reg;
            s2_luma_reg <= s1_luma_reg;
            s2_uv_reg   <= s1_uv_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: address sums into the output register.
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] luma_sum, chroma_off, u_sum, v_sum;

    always_comb begin
        luma_sum   = ADDR_W'({s2_prod_reg, 1'b0}) + ADDR_W'({s2_col_reg, 1'b0});
        chroma_off = (chroma_mode_reg == MODE_420) ? ADDR_W'(s2_prod_reg >> 1)
                                                   : ADDR_W'(s2_prod_reg);
        u_sum      = fsize_reg + chroma_off + ADDR_W'(s2_col_reg);
        v_sum      = vbase_reg + chroma_off + ADDR_W'(s2_col_reg);
    end

    logic [ADDR_W-1:0]  luma_addr_reg, u_addr_reg, v_addr_reg;
    logic [BYTE2_W-1:0] luma_pair_reg, uv_pair_reg;
    logic               chroma_write_reg;

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            luma_addr_reg    <= luma_sum;
            luma_pair_reg    <= s2_luma_reg;
            chroma_write_reg <= s2_cw_reg;
            u_addr_reg       <= s2_cw_reg ? u_sum : '0;
            v_addr_reg       <= s2_cw_reg ? v_sum : '0;
            uv_pair_reg      <= s2_cw_reg ? s2_uv_reg : '0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_luma_addr    = luma_addr_reg;
    assign m_luma_pair    = luma_pair_reg;
    assign m_chroma_write = chroma_write_reg;
    assign m_u_addr       = u_addr_reg;
    assign m_v_addr       = v_addr_reg;
    assign m_uv_pair      = uv_pair_reg;

endmodule : packed_yuv_to_planar_block_writer
`default_nettype wire

// ===== hdl/pyb_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pyb_checker
// Port-level checks of the packed YUV to planar block writer.
// ----------------------------------------------------------------------------
module pyb_checker
    import pyb_pkg::*;
(
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic [ADDR_W-1:0]  m_luma_addr,
    input wire logic [BYTE2_W-1:0] m_luma_pair,
    input wire logic               m_chroma_write,
    input wire logic [ADDR_W-1:0]  m_u_addr,
    input wire logic [ADDR_W-1:0]  m_v_addr,
    input wire logic [BYTE2_W-1:0] m_uv_pair
);

    // A word left waiting keeps its luma fields, its U address and its chroma pair.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_luma_addr) &&
            $stable(m_luma_pair) && $stable(m_u_addr) && $stable(m_uv_pair))
        else $error("result word changed while stalled");

    // Reset empties the output.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word valid after reset");

    // Without chroma the chroma fields read as zero.
    a_no_chroma: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_chroma_write |->
            m_u_addr == '0 && m_v_addr == '0 && m_uv_pair == '0)
        else $error("chroma fields set on a luma-only word");

    // Luma addresses point at the even pixel of a pair.
    a_luma_even: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !m_luma_addr[0])
        else $error("odd luma address");

endmodule : pyb_checker

bind packed_yuv_to_planar_block_writer pyb_checker u_pyb_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_luma_addr    (m_luma_addr),
    .m_luma_pair    (m_luma_pair),
    .m_chroma_write (m_chroma_write),
    .m_u_addr       (m_u_addr),
    .m_v_addr       (m_v_addr),
    .m_uv_pair      (m_uv_pair)
);
`default_nettype wire

// ===== bench/planar_write_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_write_checker
// Watches the configuration, pixel pair and planar write channels of the
// packed YUV to planar block writer. It keeps its own copy of the registers
// and of the pair position, works out the planar write each accepted pair
// word should cause and compares every result word against the oldest one.
// ----------------------------------------------------------------------------
module planar_write_checker
    import pyb_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_valid,
    input  wire logic                  s_ready,
    input  wire logic [PAIR_W-1:0]     s_pair_bytes,
    input  wire logic                  s_block_send,
    input  wire logic                  m_valid,
    input  wire logic                  m_ready,
    input  wire logic [ADDR_W-1:0]     m_luma_addr,
    input  wire logic [BYTE2_W-1:0]    m_luma_pair,
    input  wire logic                  m_chroma_write,
    input  wire logic [ADDR_W-1:0]     m_u_addr,
    input  wire logic [ADDR_W-1:0]     m_v_addr,
    input  wire logic [BYTE2_W-1:0]    m_uv_pair,
    output int                         mismatches,
    output int                         pending,
    output int                         writes_checked
);

    // One planar write as it leaves the block.
    typedef struct packed {
        logic [ADDR_W-1:0]  luma_addr;
        logic [BYTE2_W-1:0] luma_pair;
        logic               chroma_write;
        logic [ADDR_W-1:0]  u_addr;
        logic [ADDR_W-1:0]  v_addr;
        logic [BYTE2_W-1:0] uv_pair;
    } planar_write_t;

    planar_write_t expected_writes[$];

    // Shadow copy of the configuration registers.
    logic              mode_q;
    logic [BCOL_W-1:0] wide_q;
    logic [BROW_W-1:0] high_q;
    logic [BCOL_W-1:0] first_col_q;
    logic [BCOL_W-1:0] end_col_q;
    logic [BROW_W-1:0] first_row_q;
    logic [BROW_W-1:0] end_row_q;

    // Position of the next pair within the frame.
    int unsigned pair_col;
    int unsigned pix_row;

    // Works out the write caused by one pair word and moves the position on.
    function automatic void predict_write(input logic [PAIR_W-1:0] bytes,
                                          input logic flag);
        int unsigned   bw;
        int unsigned   bh;
        int unsigned   wpairs;
        int unsigned   rows;
        int unsigned   width;
        int unsigned   fsize;
        int unsigned   x;
        int unsigned   y;
        int unsigned   bx;
        int unsigned   by;
        int unsigned   ua;
        int unsigned   va;
        bit            emit;
        planar_write_t w;
        bw = (wide_q == 0) ? 1 : ((wide_q > DEF_MAX_BLOCKS_WIDE) ? DEF_MAX_BLOCKS_WIDE : wide_q);
        bh = (high_q == 0) ? 1 : ((high_q > DEF_MAX_BLOCKS_HIGH) ? DEF_MAX_BLOCKS_HIGH : high_q);
        wpairs = bw * 8;
        rows   = bh * 16;
        width  = bw * 16;
        fsize  = width * rows;

        // A size change may leave the position outside the new frame.
        if (pair_col >= wpairs) begin
            pair_col = 0;
            pix_row++;
        end
        if (pix_row >= rows)
            pix_row = 0;

        x  = pair_col * 2;
        y  = pix_row;
        bx = x >> 4;
        by = y >> 4;

        // In 4:2:0 mode only macroblocks inside the window are written.
        emit = flag;
        if (mode_q == MODE_420) begin
            if (bx < first_col_q || bx >= end_col_q || by < first_row_q || by >= end_row_q)
                emit = 0;
        end

        if (emit) begin
            w.luma_addr    = ADDR_W'(y * width + x);
            w.luma_pair    = {bytes[55:48], bytes[23:16]};
            w.chroma_write = 1'b1;
            w.u_addr       = '0;
            w.v_addr       = '0;
            w.uv_pair      = '0;
            if (mode_q == MODE_422) begin
                ua = fsize + y * (width >> 1) + (x >> 1);
                va = ua + (fsize >> 1);
            end else begin
                ua = fsize + (y >> 1) * (width >> 1) + (x >> 1);
                va = ua + (fsize >> 2);
            end
            // Odd rows carry no chroma in 4:2:0 mode.
            if (mode_q == MODE_420 && y[0]) begin
                w.chroma_write = 1'b0;
            end else begin
                w.u_addr  = ADDR_W'(ua);
                w.v_addr  = ADDR_W'(va);
                w.uv_pair = {bytes[63:56], bytes[47:40]};
            end
            expected_writes.push_back(w);
        end

        pair_col++;
        if (pair_col >= wpairs) begin
            pair_col = 0;
            pix_row++;
            if (pix_row >= rows)
                pix_row = 0;
        end
    endfunction

    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] got);
        if (want !== got) begin
            $display("%0t ns: %s expected %h actual %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Track the three channels at each rising edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            mode_q      = RST_CHROMA_MODE;
            wide_q      = RST_BLOCKS_WIDE;
            high_q      = RST_BLOCKS_HIGH;
            first_col_q = RST_FIRST_COL;
            end_col_q   = RST_END_COL;
            first_row_q = RST_FIRST_ROW;
            end_row_q   = RST_END_ROW;
            pair_col    = 0;
            pix_row     = 0;
            expected_writes.delete();
            mismatches     = 0;
            writes_checked = 0;
        end else begin
            // Result words are checked before this edge's pair is predicted.
            if (m_valid && m_ready) begin
                if (expected_writes.size() == 0) begin
                    $display("%0t ns: planar write expected none actual %h", $time,
                             m_luma_addr);
                    mismatches++;
                end else begin
                    planar_write_t w;
                    w = expected_writes.pop_front();
                    compare_field("luma_addr", w.luma_addr, m_luma_addr);
                    compare_field("luma_pair", w.luma_pair, m_luma_pair);
                    compare_field("chroma_write", w.chroma_write, m_chroma_write);
                    compare_field("u_addr", w.u_addr, m_u_addr);
                    compare_field("v_addr", w.v_addr, m_v_addr);
                    compare_field("uv_pair", w.uv_pair, m_uv_pair);
                    writes_checked++;
                end
            end

            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    REG_CHROMA_MODE: mode_q      = cfg_data[0];
                    REG_BLOCKS_WIDE: wide_q      = cfg_data[BCOL_W-1:0];
                    REG_BLOCKS_HIGH: high_q      = cfg_data[BROW_W-1:0];
                    REG_FIRST_COL:   first_col_q = cfg_data[BCOL_W-1:0];
                    REG_END_COL:     end_col_q   = cfg_data[BCOL_W-1:0];
                    REG_FIRST_ROW:   first_row_q = cfg_data[BROW_W-1:0];
                    REG_END_ROW:     end_row_q   = cfg_data[BROW_W-1:0];
                    default: ;
                endcase
            end

            if (s_valid && s_ready)
                predict_write(s_pair_bytes, s_block_send);
        end
        pending = expected_writes.size();
    end

endmodule : planar_write_checker

// ===== bench/packed_yuv_to_planar_block_writer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_yuv_to_planar_block_writer_test
// Drives pixel pair words and register writes into the block writer and
// lets the planar write checker compare every result word. A short directed
// part covers byte extremes, odd chroma rows, degenerate and oversized
// frames and an empty window; random phases then vary all registers.
// ----------------------------------------------------------------------------
module packed_yuv_to_planar_block_writer_test;
    import pyb_pkg::*;

    // Index with no register behind it; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef enum {READY_ALWAYS, READY_RANDOM, READY_BURSTY, READY_SPARSE} ready_pattern_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    logic [PAIR_W-1:0]     s_pair_bytes = '0;
    logic                  s_block_send = 1'b0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    logic [ADDR_W-1:0]     m_luma_addr;
    logic [BYTE2_W-1:0]    m_luma_pair;
    logic                  m_chroma_write;
    logic [ADDR_W-1:0]     m_u_addr;
    logic [ADDR_W-1:0]     m_v_addr;
    logic [BYTE2_W-1:0]    m_uv_pair;

    int mismatches;
    int pending;
    int writes_checked;

    ready_pattern_t ready_pattern = READY_ALWAYS;
    int             stall_left    = 0;
    int             words_sent    = 0;
    int             phases        = 0;
    int             burst_left    = 0;
    bit             dense         = 1'b1;

    always #2 aclk = ~aclk;

    packed_yuv_to_planar_block_writer i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pair_bytes   (s_pair_bytes),
        .s_block_send   (s_block_send),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_luma_addr    (m_luma_addr),
        .m_luma_pair    (m_luma_pair),
        .m_chroma_write (m_chroma_write),
        .m_u_addr       (m_u_addr),
        .m_v_addr       (m_v_addr),
        .m_uv_pair      (m_uv_pair)
    );

    planar_write_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pair_bytes   (s_pair_bytes),
        .s_block_send   (s_block_send),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_luma_addr    (m_luma_addr),
        .m_luma_pair    (m_luma_pair),
        .m_chroma_write (m_chroma_write),
        .m_u_addr       (m_u_addr),
        .m_v_addr       (m_v_addr),
        .m_uv_pair      (m_uv_pair),
        .mismatches     (mismatches),
        .pending        (pending),
        .writes_checked (writes_checked)
    );

    // Receiver back-pressure, following the pattern chosen for the phase.
    always @(posedge aclk) begin
        case (ready_pattern)
            READY_ALWAYS: m_ready <= 1'b1;
            READY_RANDOM: m_ready <= ($urandom_range(0, 3) != 0);
            READY_BURSTY: begin
                if (stall_left == 0) begin
                    m_ready    <= !m_ready;
                    stall_left <= $urandom_range(1, 12);
                end else begin
                    stall_left <= stall_left - 1;
                end
            end
            default: m_ready <= ($urandom_range(0, 2) == 0);
        endcase
    end

    // Hold one register write until it is taken; the caller lowers valid.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Write all seven registers back to back while the block is idle.
    task automatic write_settings(input logic [CFG_DATA_W-1:0] mode,
                                  input logic [CFG_DATA_W-1:0] wide,
                                  input logic [CFG_DATA_W-1:0] high,
                                  input logic [CFG_DATA_W-1:0] first_col,
                                  input logic [CFG_DATA_W-1:0] end_col,
                                  input logic [CFG_DATA_W-1:0] first_row,
                                  input logic [CFG_DATA_W-1:0] end_row,
                                  input bit poke_unused);
        write_reg(REG_CHROMA_MODE, mode);
        write_reg(REG_BLOCKS_WIDE, wide);
        write_reg(REG_BLOCKS_HIGH, high);
        write_reg(REG_FIRST_COL, first_col);
        write_reg(REG_END_COL, end_col);
        write_reg(REG_FIRST_ROW, first_row);
        write_reg(REG_END_ROW, end_row);
        if (poke_unused)
            write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 127)));
        cfg_valid <= 1'b0;
    endtask

    // Send one pair word; between bursts, unless pacing is dense, it opens a random gap.
    task automatic send_pair(input logic [PAIR_W-1:0] bytes, input logic flag);
        int gap;
        if (burst_left == 0) begin
            gap = dense ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_valid      <= 1'b1;
        s_pair_bytes <= bytes;
        s_block_send <= flag;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
    endtask

    // Stop sending and wait until every expected write has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    initial begin
        logic [PAIR_W-1:0]     patterns[6];
        logic [PAIR_W-1:0]     bytes;
        logic [CFG_DATA_W-1:0] wide;
        logic [CFG_DATA_W-1:0] high;
        logic [CFG_DATA_W-1:0] fc;
        logic [CFG_DATA_W-1:0] ec;
        logic [CFG_DATA_W-1:0] fr;
        logic [CFG_DATA_W-1:0] er;
        int                    eff_w;
        int                    eff_h;
        int                    count;
        int                    k;
        patterns[0] = '0;
        patterns[1] = '1;
        patterns[2] = 64'h0123_4567_89AB_CDEF;
        patterns[3] = 64'hFEDC_BA98_7654_3210;
        patterns[4] = 64'hAAAA_AAAA_AAAA_AAAA;
        patterns[5] = 64'h5555_5555_5555_5555;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        ready_pattern <= READY_RANDOM;

        // Reset settings: 4:2:0 over a 22x18 frame, first row.
        for (k = 0; k < 4; k++)
            send_pair(patterns[k], k != 3);
        drain_results();

        // Zero frame size taken as one block; crosses into an odd row.
        write_settings(CFG_DATA_W'(MODE_420), 0, 0, 0, 1, 0, 1, 1'b1);
        for (k = 0; k < 9; k++)
            send_pair(patterns[k % 6], k != 5);
        drain_results();

        // Oversized frame saturates; 4:2:2 with chroma on every row.
        write_settings(CFG_DATA_W'(MODE_422), 127, 63, 0, 0, 0, 0, 1'b0);
        for (k = 0; k < 8; k++)
            send_pair(patterns[(k + 2) % 6], 1'b1);
        drain_results();

        // Shrinking the frame puts the position past the row end; empty window.
        write_settings(CFG_DATA_W'(MODE_420), 1, 1, 0, 0, 0, 0, 1'b0);
        send_pair(patterns[1], 1'b1);
        send_pair(patterns[2], 1'b1);
        phases = 4;

        // Random phases, each with its own settings, pacing and back-pressure.
        while (words_sent < 1950) begin
            drain_results();
            case ($urandom_range(0, 9))
                0:       wide = 0;
                1:       wide = CFG_DATA_W'($urandom_range(64, 127));
                2:       wide = CFG_DATA_W'($urandom_range(5, 63));
                default: wide = CFG_DATA_W'($urandom_range(1, 4));
            endcase
            case ($urandom_range(0, 9))
                0:       high = 0;
                1:       high = CFG_DATA_W'($urandom_range(48, 63));
                2:       high = CFG_DATA_W'($urandom_range(4, 47));
                default: high = CFG_DATA_W'($urandom_range(1, 3));
            endcase
            eff_w = (wide == 0) ? 1 : ((wide > DEF_MAX_BLOCKS_WIDE) ? DEF_MAX_BLOCKS_WIDE : wide);
            eff_h = (high[5:0] == 0) ? 1 :
                    ((high[5:0] > DEF_MAX_BLOCKS_HIGH) ? DEF_MAX_BLOCKS_HIGH : high[5:0]);
            // Mostly a window that overlaps the frame, sometimes anything.
            if ($urandom_range(0, 5) == 0) begin
                fc = CFG_DATA_W'($urandom_range(0, 127));
                ec = CFG_DATA_W'($urandom_range(0, 127));
                fr = CFG_DATA_W'($urandom_range(0, 127));
                er = CFG_DATA_W'($urandom_range(0, 127));
            end else begin
                fc = CFG_DATA_W'($urandom_range(0, eff_w - 1));
                ec = CFG_DATA_W'($urandom_range(fc + 1, eff_w + 1));
                fr = CFG_DATA_W'($urandom_range(0, eff_h - 1));
                er = CFG_DATA_W'($urandom_range(fr + 1, eff_h + 1));
            end
            write_settings(CFG_DATA_W'($urandom_range(0, 127)), wide, high, fc, ec, fr, er,
                           $urandom_range(0, 3) == 0);
            ready_pattern <= ready_pattern_t'($urandom_range(0, 3));
            dense      = ($urandom_range(0, 3) == 0);
            burst_left = 0;
            count      = $urandom_range(40, 160);
            for (k = 0; k < count; k++) begin
                case ($urandom_range(0, 9))
                    0:       bytes = '1;
                    1:       bytes = '0;
                    default: bytes = {$urandom, $urandom};
                endcase
                send_pair(bytes, $urandom_range(0, 3) != 0);
            end
            phases++;
        end

        drain_results();
        repeat (10) @(posedge aclk);
        $display("Sent %0d pair words over %0d register settings; %0d planar writes checked.",
                 words_sent, phases, writes_checked);
        $display("Settings spanned both chroma modes, zero and saturated frame sizes and "
                 , "empty, partial and full windows.");
        if (mismatches == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Give up if the run hangs.
    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule : packed_yuv_to_planar_block_writer_test

// ===== filelist.f =====
hdl/pyb_pkg.sv
hdl/pyb_position.sv
hdl/packed_yuv_to_planar_block_writer.sv
hdl/pyb_checker.sv
bench/planar_write_checker.sv
bench/packed_yuv_to_planar_block_writer_test.sv
